// ===== design/sha1bsh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Shared types, constants and round functions for the SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

    localparam int ROUND_COUNT = 80;
    localparam int CHAIN_COUNT = 5;

    localparam logic [0:0] OP_ABSORB   = 1'b0;
    localparam logic [0:0] OP_FINALIZE = 1'b1;

    localparam logic [7:0] PAD_MARKER  = 8'h80;
    localparam logic [7:0] PAD_ZERO    = 8'h00;
    localparam logic [5:0] POS_LEN     = 6'd56;
    localparam logic [5:0] POS_LAST    = 6'd63;
    localparam logic [6:0] ROUND_LAST  = 7'(ROUND_COUNT - 1);
    localparam logic [2:0] EMIT_LAST   = 3'(CHAIN_COUNT - 1);

    localparam logic [31:0] H_INIT [CHAIN_COUNT] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    typedef struct packed {
        logic [0:0] op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic       load_byte;
        logic       shift_word;
        logic [7:0] data;
    } sched_ctrl_t;

    typedef struct packed {
        logic start;
        logic step;
        logic fold;
        logic shift_out;
        logic restart;
    } round_ctrl_t;

    function automatic logic [31:0] round_k(input logic [6:0] idx);
        logic [31:0] k;
        if (idx < 7'd20) begin
            k = K_0;
        end else if (idx < 7'd40) begin
            k = K_1;
        end else if (idx < 7'd60) begin
            k = K_2;
        end else begin
            k = K_3;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] idx, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (idx < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (idx < 7'd40) begin
            f = b ^ c ^ d;
        end else if (idx < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ===== design/sha1bsh_schedule.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// Collects message bytes into a 512-bit block and expands it one word per
// round through a sixteen-word shift line.
// ----------------------------------------------------------------------------
module sha1bsh_schedule (
    input  logic                     clk,
    input  sha1bsh_pkg::sched_ctrl_t ctrl,
    output logic [31:0]              w_word
);
    import sha1bsh_pkg::*;

    logic [511:0] sched_reg;
    logic [511:0] sched_next;
    logic [31:0]  expand_x;
    logic [31:0]  expand_w;

    assign w_word   = sched_reg[511:480];
    assign expand_x = sched_reg[511:480] ^ sched_reg[447:416] ^ sched_reg[255:224]
                    ^ sched_reg[95:64];
    assign expand_w = {expand_x[30:0], expand_x[31]};

    always_comb
    begin
        sched_next = sched_reg;
        if (ctrl.load_byte) begin
            sched_next = {sched_reg[503:0], ctrl.data};
        end else if (ctrl.shift_word) begin
            sched_next = {sched_reg[479:0], expand_w};
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
    end

endmodule

// ===== design/sha1bsh_round.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Holds the chaining words and the working variables, and applies one
// compression round per step.
// ----------------------------------------------------------------------------
module sha1bsh_round (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha1bsh_pkg::round_ctrl_t ctrl,
    input  logic [6:0]               round_idx,
    input  logic [31:0]              w_word,
    output logic [31:0]              chain_head
);
    import sha1bsh_pkg::*;

    logic [31:0] chain_reg [CHAIN_COUNT];
    logic [31:0] chain_next [CHAIN_COUNT];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] temp;

    assign chain_head = chain_reg[0];
    assign temp = {a_reg[26:0], a_reg[31:27]} + round_f(round_idx, b_reg, c_reg, d_reg)
                + e_reg + round_k(round_idx) + w_word;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        chain_next = chain_reg;
        if (ctrl.start) begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end else if (ctrl.step) begin
            a_next = temp;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
        if (ctrl.fold) begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end else if (ctrl.restart) begin
            chain_next = H_INIT;
        end else if (ctrl.shift_out) begin
            for (int i = 0; i < CHAIN_COUNT - 1; i++) begin
                chain_next[i] = chain_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chain_reg <= H_INIT;
        end else begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

endmodule

// ===== design/sha1_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Absorbs a message one byte per word and returns its SHA-1 digest as five
// 32-bit words on finalize.
// ----------------------------------------------------------------------------
// Each absorb word is loaded into the block; the one that fills a 64-byte block
// then occupies the block for a compression: its 80 rounds through the
// single round unit and a fold of the result into the chaining words.
// A finalize word inserts the padding one byte per cycle outside the one or two
// such compressions that it needs, and then offers the five digest words, the
// first chaining word first, the fifth marked as last. The block takes no input
// word while it compresses, pads or emits, and it starts a fresh message afterward.
module sha1_byte_stream_hasher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sha1bsh_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sha1bsh_pkg::out_item_t out_data
);
    import sha1bsh_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic        fin_reg, fin_next;
    logic        marker_reg, marker_next;
    logic        lenph_reg, lenph_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  emit_reg, emit_next;
    logic        in_fire;
    logic        out_fire;
    logic        len_sel;
    sched_ctrl_t sched_ctrl;
    round_ctrl_t round_ctrl;
    logic [31:0] w_word;
    logic [31:0] chain_head;

    sha1bsh_schedule u_schedule (
        .clk    (clk),
        .ctrl   (sched_ctrl),
        .w_word (w_word)
    );

    sha1bsh_round u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (round_ctrl),
        .round_idx  (round_reg),
        .w_word     (w_word),
        .chain_head (chain_head)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign len_sel   = marker_reg && (lenph_reg || (pos_reg == POS_LEN));

    assign out_data.digest_word = chain_head;
    assign out_data.last        = (emit_reg == EMIT_LAST);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        fin_next    = fin_reg;
        marker_next = marker_reg;
        lenph_next  = lenph_reg;
        round_next  = round_reg;
        emit_next   = emit_reg;
        sched_ctrl  = '0;
        round_ctrl  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    if (in_data.op == OP_FINALIZE) begin
                        fin_next    = 1'b1;
                        marker_next = 1'b0;
                        lenph_next  = 1'b0;
                        state_next  = ST_PAD;
                    end else begin
                        sched_ctrl.load_byte = 1'b1;
                        sched_ctrl.data      = in_data.data_byte;
                        pos_next = pos_reg + 6'd1;
                        len_next = len_reg + 64'd8;
                        if (pos_reg == POS_LAST) begin
                            round_ctrl.start = 1'b1;
                            round_next = '0;
                            state_next = ST_ROUND;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                sched_ctrl.load_byte = 1'b1;
                if (!marker_reg) begin
                    sched_ctrl.data = PAD_MARKER;
                    marker_next = 1'b1;
                end else if (len_sel) begin
                    sched_ctrl.data = len_reg[63:56];
                    len_next   = {len_reg[55:0], 8'h00};
                    lenph_next = 1'b1;
                end else begin
                    sched_ctrl.data = PAD_ZERO;
                end
                pos_next = pos_reg + 6'd1;
                if (pos_reg == POS_LAST) begin
                    round_ctrl.start = 1'b1;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                round_ctrl.step       = 1'b1;
                sched_ctrl.shift_word = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                round_ctrl.fold = 1'b1;
                if (fin_reg && lenph_reg) begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_fire) begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == EMIT_LAST) begin
                        round_ctrl.restart = 1'b1;
                        pos_next   = '0;
                        len_next   = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        round_ctrl.shift_out = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            len_reg    <= '0;
            fin_reg    <= 1'b0;
            marker_reg <= 1'b0;
            lenph_reg  <= 1'b0;
            round_reg  <= '0;
            emit_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            fin_reg    <= fin_next;
            marker_reg <= marker_next;
            lenph_reg  <= lenph_next;
            round_reg  <= round_next;
            emit_reg   <= emit_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && in_ready))
        else $error("digest offered while input is open");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= ROUND_LAST))
        else $error("round counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg == '0 && fin_reg && lenph_reg))
        else $error("digest emitted before padding completed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_data.last) |=> (state_reg == ST_IDLE && len_reg == '0))
        else $error("hasher not restarted after last digest word");
`endif

endmodule
